/* rtl/core/pedo_pkg.sv */
// Shared types and constants for the pedometer step detector.
`timescale 1ns / 1ps
`default_nettype none

package pedo_pkg;

    localparam int MAG_W    = 8;
    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_STREAK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RISE   = 3'd4;

    localparam logic [7:0] THRESHOLD_RST  = 8'd94;
    localparam logic [7:0] MIN_GAP_RST    = 8'd9;
    localparam logic [7:0] MAX_GAP_RST    = 8'd30;
    localparam logic [3:0] MIN_STREAK_RST = 4'd7;
    localparam logic [6:0] MAX_RISE_RST   = 7'd19;

    localparam logic [6:0] RISE_SCALE = 7'd100;
    localparam logic [7:0] STREAK_MAX = 8'hff;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef enum logic [2:0] {
        OUT_BELOW     = 3'd0,
        OUT_TOO_SOON  = 3'd1,
        OUT_RISE_REJ  = 3'd2,
        OUT_TAKEN     = 3'd3,
        OUT_CLEARED   = 3'd4
    } t_outcome;

    // control broadcast to every cell of the rise chain
    typedef struct packed {
        logic             shift;
        logic             clear;
        logic [MAG_W-1:0] rise;
    } t_cell_ctl;

endpackage

`default_nettype wire

/* rtl/core/pedometer_step_detector_unit.sv */
// Top level of the pedometer step detector: magnitude stage, rise chain, step logic.
//
//  channel   direction  handshake                  payload
//  in        input      i_in_valid / o_in_ready    i_op, i_sample_x/y/z
//  out       output     o_out_valid / i_out_ready  o_step_total, o_steps_added,
//                                                  o_magnitude, o_outcome,
//                                                  o_streak_length
//  cfg       input      i_cfg_we (no wait)         i_cfg_idx, i_cfg_wdata
//
//  One beat per cycle while the output is not stalled; a taken beat lands in
//  the magnitude register, then the decision and state update load the
//  output register, which holds the result until i_out_ready takes it.
//  The rise chain holds HISTORY_DEPTH-2 cells, so the steepest rise is ready
//  in the decision cycle without walking the history.
//  Synchronous reset clears counters and the chain and reloads the register
//  defaults.
//  A stalled output holds both stages; o_in_ready drops only while both
//  stages are full and i_out_ready is low.
`timescale 1ns / 1ps
`default_nettype none

module pedometer_step_detector_unit import pedo_pkg::*; #(
    parameter int HISTORY_DEPTH = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_op,
    input  logic signed [SAMPLE_W-1:0] i_sample_x,
    input  logic signed [SAMPLE_W-1:0] i_sample_y,
    input  logic signed [SAMPLE_W-1:0] i_sample_z,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [COUNT_W-1:0]         o_step_total,
    output logic [3:0]                 o_steps_added,
    output logic [MAG_W-1:0]           o_magnitude,
    output logic [2:0]                 o_outcome,
    output logic [7:0]                 o_streak_length
);

    localparam int NCELLS = HISTORY_DEPTH - 2;

    // configuration
    logic [7:0] r_thr, r_min_gap, r_max_gap;
    logic [3:0] r_min_streak;
    logic [6:0] r_max_rise;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr        <= THRESHOLD_RST;
            r_min_gap    <= MIN_GAP_RST;
            r_max_gap    <= MAX_GAP_RST;
            r_min_streak <= MIN_STREAK_RST;
            r_max_rise   <= MAX_RISE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_THRESHOLD:  r_thr        <= i_cfg_wdata;
                REG_MIN_GAP:    r_min_gap    <= i_cfg_wdata;
                REG_MAX_GAP:    r_max_gap    <= i_cfg_wdata;
                REG_MIN_STREAK: r_min_streak <= i_cfg_wdata[3:0];
                REG_MAX_RISE:   r_max_rise   <= i_cfg_wdata[6:0];
                default: begin
                end
            endcase
        end
    end

    // handshake
    logic r_s1_valid, r_out_valid;
    logic out_adv, s1_adv, in_acc;

    assign out_adv    = !r_out_valid || i_out_ready;
    assign s1_adv     = r_s1_valid && out_adv;
    assign o_in_ready = !r_s1_valid || out_adv;
    assign in_acc     = i_in_valid && o_in_ready;

    // stage 1: magnitude
    logic [MAG_W-1:0] w_mag;
    logic             r_s1_op;
    logic [MAG_W-1:0] r_s1_mag;

    pedo_mag u_mag (
        .i_x   (i_sample_x),
        .i_y   (i_sample_y),
        .i_z   (i_sample_z),
        .o_mag (w_mag)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_op  <= i_op;
            r_s1_mag <= w_mag;
        end
    end

    // rise chain
    logic [MAG_W-1:0] r_h0, n_h0;
    logic [MAG_W-1:0] new_rise, rise;
    logic [MAG_W-1:0] w_q [NCELLS];
    t_cell_ctl        cell_ctl;
    logic             is_clear;

    assign is_clear = (r_s1_op == OP_CLEAR);
    assign new_rise = (r_s1_mag > r_h0) ? (r_s1_mag - r_h0) : '0;
    assign rise     = (w_q[NCELLS-1] > new_rise) ? w_q[NCELLS-1] : new_rise;

    assign cell_ctl.shift = s1_adv && !is_clear;
    assign cell_ctl.clear = s1_adv && is_clear;
    assign cell_ctl.rise  = new_rise;

    for (genvar k = 0; k < NCELLS; k++) begin : g_cell
        if (k == 0) begin : g_head
            pedo_rise_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctl    (cell_ctl),
                .i_left_q ('0),
                .o_q      (w_q[k])
            );
        end else begin : g_body
            pedo_rise_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctl    (cell_ctl),
                .i_left_q (w_q[k-1]),
                .o_q      (w_q[k])
            );
        end
    end

    // stage 2: step decision
    logic [COUNT_W-1:0] r_sample_cnt, n_sample_cnt;
    logic [COUNT_W-1:0] r_last_step, n_last_step;
    logic               r_have_prev, n_have_prev;
    logic [7:0]         r_streak, n_streak;
    logic [COUNT_W-1:0] r_step_cnt, n_step_cnt;

    logic [COUNT_W-1:0] gap;
    logic [14:0]        rise_lhs, rise_rhs;
    logic [COUNT_W:0]   step_sum;
    logic [3:0]         added;
    t_outcome           outcome;

    logic [COUNT_W-1:0] r_out_total;
    logic [3:0]         r_out_added;
    logic [MAG_W-1:0]   r_out_mag;
    t_outcome           r_out_outcome;
    logic [7:0]         r_out_streak;

    assign gap      = r_sample_cnt - r_last_step;
    assign rise_lhs = 15'(rise) * 15'(RISE_SCALE);
    assign rise_rhs = 15'(r_max_rise) * 15'(r_s1_mag);

    always_comb begin
        n_sample_cnt = r_sample_cnt;
        n_last_step  = r_last_step;
        n_have_prev  = r_have_prev;
        n_streak     = r_streak;
        n_step_cnt   = r_step_cnt;
        n_h0         = r_h0;
        added        = '0;
        outcome      = OUT_BELOW;
        step_sum     = '0;
        if (is_clear) begin
            n_sample_cnt = '0;
            n_last_step  = '0;
            n_have_prev  = 1'b0;
            n_streak     = '0;
            n_step_cnt   = '0;
            n_h0         = '0;
            outcome      = OUT_CLEARED;
        end else begin
            n_h0         = r_s1_mag;
            n_sample_cnt = r_sample_cnt + 32'd1;
            if (r_s1_mag <= r_thr) begin
                outcome = OUT_BELOW;
            end else if (r_have_prev && gap < {24'd0, r_min_gap}) begin
                outcome = OUT_TOO_SOON;
            end else if (rise_lhs > rise_rhs) begin
                outcome = OUT_RISE_REJ;
            end else begin
                outcome = OUT_TAKEN;
                if (r_have_prev && gap <= {24'd0, r_max_gap}) begin
                    n_streak = (r_streak == STREAK_MAX) ? r_streak : r_streak + 8'd1;
                end else begin
                    n_streak = 8'd1;
                end
                // whole streak credited once it reaches the minimum length
                if (n_streak == {4'd0, r_min_streak}) begin
                    added = r_min_streak;
                end else if (n_streak > {4'd0, r_min_streak}) begin
                    added = 4'd1;
                end
                step_sum    = {1'b0, r_step_cnt} + 33'(added);
                n_step_cnt  = step_sum[COUNT_W] ? '1 : step_sum[COUNT_W-1:0];
                n_have_prev = 1'b1;
                n_last_step = r_sample_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_cnt <= '0;
            r_last_step  <= '0;
            r_have_prev  <= 1'b0;
            r_streak     <= '0;
            r_step_cnt   <= '0;
            r_h0         <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_sample_cnt <= n_sample_cnt;
                r_last_step  <= n_last_step;
                r_have_prev  <= n_have_prev;
                r_streak     <= n_streak;
                r_step_cnt   <= n_step_cnt;
                r_h0         <= n_h0;
            end
            if (out_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_total   <= n_step_cnt;
            r_out_added   <= added;
            r_out_mag     <= is_clear ? '0 : r_s1_mag;
            r_out_outcome <= outcome;
            r_out_streak  <= n_streak;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_step_total    = r_out_total;
    assign o_steps_added   = r_out_added;
    assign o_magnitude     = r_out_mag;
    assign o_outcome       = 3'(r_out_outcome);
    assign o_streak_length = r_out_streak;

    // checks
    a_added_only_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_added != 4'd0) |-> (r_out_outcome == OUT_TAKEN))
        else $error("steps credited without a taken candidate");

    a_taken_sets_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && outcome == OUT_TAKEN) |=> (r_have_prev && r_streak != 8'd0))
        else $error("taken candidate left no previous step");

    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && !is_clear) |=> (r_step_cnt >= $past(r_step_cnt)))
        else $error("step count fell without a clear");

    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && is_clear) |=> (r_step_cnt == '0 && r_h0 == '0 && w_q[NCELLS-1] == '0))
        else $error("clear left state behind");

endmodule

`default_nettype wire

/* rtl/core/pedo_mag.sv */
// Approximate vector magnitude of one three-axis sample, scaled to 8 bits.
`timescale 1ns / 1ps
`default_nettype none

module pedo_mag import pedo_pkg::*; (
    input  logic signed [SAMPLE_W-1:0] i_x,
    input  logic signed [SAMPLE_W-1:0] i_y,
    input  logic signed [SAMPLE_W-1:0] i_z,
    output logic        [MAG_W-1:0]    o_mag
);

    logic [15:0] ax, ay, az;
    logic [15:0] s0a, s0b, s1b, s1c, hi, mid, lo;
    logic [19:0] mid15;
    logic [17:0] lo3;
    logic [16:0] sum;

    // absolute values; the most negative code maps to 0x8000, which fits
    assign ax = i_x[15] ? (~i_x + 16'd1) : i_x;
    assign ay = i_y[15] ? (~i_y + 16'd1) : i_y;
    assign az = i_z[15] ? (~i_z + 16'd1) : i_z;

    always_comb begin
        // three compare-exchange steps
        s0a = (ax < ay) ? ay : ax;
        s0b = (ax < ay) ? ax : ay;
        s1b = (s0b < az) ? az : s0b;
        s1c = (s0b < az) ? s0b : az;
        hi  = (s0a < s1b) ? s1b : s0a;
        mid = (s0a < s1b) ? s0a : s1b;
        lo  = s1c;
        mid15 = {mid, 4'd0} - {4'd0, mid};
        lo3   = {1'b0, lo, 1'b0} + {2'd0, lo};
        sum   = {1'b0, hi} + 17'(mid15[19:4]) + 17'(lo3[17:3]);
        // clamp to 16 bits, keep the top byte
        o_mag = sum[16] ? 8'hff : sum[15:8];
    end

endmodule

`default_nettype wire

/* rtl/core/pedo_rise_cell.sv */
// One cell of the rise chain: running maximum of neighbour rises in the history.
`timescale 1ns / 1ps
`default_nettype none

module pedo_rise_cell import pedo_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctl        i_ctl,
    input  logic [MAG_W-1:0] i_left_q,
    output logic [MAG_W-1:0] o_q
);

    logic [MAG_W-1:0] r_q, n_q;

    always_comb begin
        n_q = r_q;
        if (i_ctl.clear) begin
            n_q = '0;
        end else if (i_ctl.shift) begin
            // pairs move one place older; fold in the newest pair
            n_q = (i_ctl.rise > i_left_q) ? i_ctl.rise : i_left_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for the pedometer step detector: each output beat is checked against a prediction.
`timescale 1ns / 1ps

module testbench;
    import pedo_pkg::*;

    localparam int HIST_DEPTH  = 8;
    localparam int PHASES      = 10;
    localparam int PHASE_BEATS = 145;
    localparam int LONG_HOLD   = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int MAX_PRINTED = 30;

    typedef struct packed {
        logic                       op;
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] y;
        logic signed [SAMPLE_W-1:0] z;
    } t_beat;

    typedef struct packed {
        logic [COUNT_W-1:0] total;
        logic [3:0]         added;
        logic [MAG_W-1:0]   mag;
        t_outcome           outcome;
        logic [7:0]         streak;
    } t_report;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_wdata = '0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic                       i_op = OP_SAMPLE;
    logic signed [SAMPLE_W-1:0] i_sample_x = '0;
    logic signed [SAMPLE_W-1:0] i_sample_y = '0;
    logic signed [SAMPLE_W-1:0] i_sample_z = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic [COUNT_W-1:0]         o_step_total;
    logic [3:0]                 o_steps_added;
    logic [MAG_W-1:0]           o_magnitude;
    logic [2:0]                 o_outcome;
    logic [7:0]                 o_streak_length;

    pedometer_step_detector_unit #(.HISTORY_DEPTH(HIST_DEPTH)) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_op            (i_op),
        .i_sample_x      (i_sample_x),
        .i_sample_y      (i_sample_y),
        .i_sample_z      (i_sample_z),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_step_total    (o_step_total),
        .o_steps_added   (o_steps_added),
        .o_magnitude     (o_magnitude),
        .o_outcome       (o_outcome),
        .o_streak_length (o_streak_length)
    );

    always #2 i_clk = ~i_clk;

    // predictor copy of the registers
    logic [7:0] cfg_threshold  = THRESHOLD_RST;
    logic [7:0] cfg_min_gap    = MIN_GAP_RST;
    logic [7:0] cfg_max_gap    = MAX_GAP_RST;
    logic [3:0] cfg_min_streak = MIN_STREAK_RST;
    logic [6:0] cfg_max_rise   = MAX_RISE_RST;

    // predictor copy of the detector state
    logic [31:0] samples_seen  = '0;
    logic [31:0] last_step_at  = '0;
    logic        step_seen     = 1'b0;
    logic [7:0]  run_count     = '0;
    logic [31:0] steps_counted = '0;
    logic [7:0]  recent_mags [HIST_DEPTH] = '{default: '0};
    int          hist_wr       = 0;

    t_beat   accel_beats [$];
    t_report predicted_reports [$];

    int   mismatch_count = 0;
    int   phase_fill     = 0;
    int   idle_odds      = 0;
    logic quiet_tail     = 1'b0;
    logic hold_request   = 1'b0;

    function automatic int unsigned axis_abs(logic signed [SAMPLE_W-1:0] v);
        return v[SAMPLE_W-1] ? (32'h1_0000 - {16'h0, v}) : {16'h0, v};
    endfunction

    function automatic t_report predict_report(t_beat b);
        int unsigned hi, mid, lo, tmp, norm, rise, gap, added;
        logic [7:0]  mag, prev, cur;
        int          pos;
        t_report     r;
        r = '0;
        if (b.op == OP_CLEAR) begin
            samples_seen  = '0;
            last_step_at  = '0;
            step_seen     = 1'b0;
            run_count     = '0;
            steps_counted = '0;
            for (int i = 0; i < HIST_DEPTH; i++) recent_mags[i] = '0;
            hist_wr = 0;
            r.outcome = OUT_CLEARED;
            return r;
        end
        hi  = axis_abs(b.x);
        mid = axis_abs(b.y);
        lo  = axis_abs(b.z);
        if (hi < mid) begin tmp = hi;  hi = mid; mid = tmp; end
        if (mid < lo) begin tmp = mid; mid = lo; lo = tmp;  end
        if (hi < mid) begin tmp = hi;  hi = mid; mid = tmp; end
        norm = hi + ((15 * mid) >> 4) + ((3 * lo) >> 3);
        if (norm > 32'hffff) norm = 32'hffff;
        mag = norm[15:8];

        recent_mags[hist_wr] = mag;
        hist_wr = (hist_wr + 1) % HIST_DEPTH;

        // steepest climb between neighbours, oldest entry first
        pos  = hist_wr;
        prev = recent_mags[pos];
        rise = 0;
        for (int k = 1; k < HIST_DEPTH; k++) begin
            cur = recent_mags[(pos + k) % HIST_DEPTH];
            if (cur > prev && int'(cur - prev) > rise) rise = cur - prev;
            prev = cur;
        end

        gap   = samples_seen - last_step_at;
        added = 0;
        if (mag <= cfg_threshold) begin
            r.outcome = OUT_BELOW;
        end else if (step_seen && gap < cfg_min_gap) begin
            r.outcome = OUT_TOO_SOON;
        end else if (rise * RISE_SCALE > int'(cfg_max_rise) * int'(mag)) begin
            r.outcome = OUT_RISE_REJ;
        end else begin
            r.outcome = OUT_TAKEN;
            if (step_seen && gap <= cfg_max_gap) begin
                if (run_count != STREAK_MAX) run_count++;
            end else begin
                run_count = 8'd1;
            end
            // credit the whole streak once it first reaches the minimum
            if (run_count == {4'h0, cfg_min_streak}) added = cfg_min_streak;
            else if (run_count > {4'h0, cfg_min_streak}) added = 1;
            if (32'hffff_ffff - steps_counted < added) steps_counted = 32'hffff_ffff;
            else steps_counted = steps_counted + added;
            step_seen    = 1'b1;
            last_step_at = samples_seen;
        end
        samples_seen = samples_seen + 1;

        r.total  = steps_counted;
        r.added  = added[3:0];
        r.mag    = mag;
        r.streak = run_count;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) $display("%0t ns: %s", $time, msg);
    endtask

    task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
    endtask

    // driver: offer queued beats, with random idle bursts
    t_beat held_beat;
    int    send_gap = 0;

    always @(posedge i_clk) begin : drive_beats
        t_beat nxt;
        logic  offer;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   <= 0;
        end else if (i_in_valid && !o_in_ready) begin
            // hold the beat until taken
        end else begin
            if (i_in_valid) predicted_reports.push_back(predict_report(held_beat));
            offer = 1'b0;
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (accel_beats.size() != 0) begin
                if (!quiet_tail && idle_odds != 0 && $urandom_range(idle_odds - 1, 0) == 0) begin
                    send_gap <= $urandom_range(17, 0);
                end else begin
                    offer      = 1'b1;
                    nxt        = accel_beats.pop_front();
                    held_beat  <= nxt;
                    i_op       <= nxt.op;
                    i_sample_x <= nxt.x;
                    i_sample_y <= nxt.y;
                    i_sample_z <= nxt.z;
                end
            end
            i_in_valid <= offer;
        end
    end

    // monitor: check each output beat, stall at random
    int   recv_gap  = 0;
    int   hold_left = 0;
    logic hold_done = 1'b0;

    always @(posedge i_clk) begin : check_reports
        t_report want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (predicted_reports.size() == 0) begin
                    report_mismatch("result beat with nothing predicted");
                end else begin
                    want = predicted_reports.pop_front();
                    compare_field("step_total", o_step_total, want.total);
                    compare_field("steps_added", o_steps_added, want.added);
                    compare_field("magnitude", o_magnitude, want.mag);
                    compare_field("outcome", o_outcome, want.outcome);
                    compare_field("streak_length", o_streak_length, want.streak);
                end
            end
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                i_out_ready <= 1'b0;
            end else if (!quiet_tail && idle_odds != 0
                         && $urandom_range(idle_odds - 1, 0) == 0) begin
                recv_gap = $urandom_range(17, 0);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // watchdog: give up after a long stretch with no beat on either side
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic add_beat(logic op, int x, int y, int z);
        t_beat b;
        b.op = op;
        b.x  = x[15:0];
        b.y  = y[15:0];
        b.z  = z[15:0];
        accel_beats.push_back(b);
        phase_fill++;
    endtask

    // sample whose magnitude lands near lvl, axes shuffled and signs random
    task automatic add_level(int lvl);
        int target, j, tmp;
        int v[3];
        if (lvl < 0) lvl = 0;
        if (lvl > 255) lvl = 255;
        target = lvl * 256 + $urandom_range(255, 0);
        if (target <= 32000) begin
            v[0] = target;
            v[1] = $urandom_range(255, 0);
            v[2] = $urandom_range(255, 0);
        end else begin
            v[0] = $urandom_range(32767, 30000);
            v[1] = (target - v[0]) * 16 / 15;
            if (v[1] > 32767) v[1] = 32767;
            v[2] = $urandom_range(1500, 0);
        end
        for (int i = 0; i < 3; i++) begin
            j    = $urandom_range(2, 0);
            tmp  = v[i];
            v[i] = v[j];
            v[j] = tmp;
        end
        for (int i = 0; i < 3; i++) if ($urandom_range(1, 0) == 1) v[i] = -v[i];
        add_beat(OP_SAMPLE, v[0], v[1], v[2]);
    endtask

    // walking pattern: one triangular peak per stride, spaced around the gap window
    task automatic add_walk(int strides);
        int lo, hi, period, base, peak, half, d;
        lo = (cfg_min_gap < 2) ? 2 : cfg_min_gap;
        hi = (cfg_max_gap > lo) ? cfg_max_gap : lo + 4;
        if (hi > 40) hi = (lo > 40) ? lo : 40;
        base = $urandom_range(cfg_threshold / 2, 0);
        peak = cfg_threshold + $urandom_range(90, 4);
        if (peak > 255) peak = 255;
        for (int s = 0; s < strides && phase_fill < PHASE_BEATS; s++) begin
            period = $urandom_range(hi, lo);
            half   = period / 2;
            for (int i = 0; i < period; i++) begin
                d = (i <= half) ? i : period - i;
                add_level(base + (peak - base) * d / half);
            end
        end
    endtask

    task automatic add_steady(int count);
        int lvl;
        lvl = $urandom_range(200, 100);
        repeat (count) add_level(lvl + $urandom_range(1, 0));
    endtask

    task automatic add_noise(int count);
        repeat (count)
            add_beat(($urandom_range(39, 0) == 0) ? OP_CLEAR : OP_SAMPLE,
                     $urandom, $urandom, $urandom);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        case (idx)
            REG_THRESHOLD:  cfg_threshold  = data;
            REG_MIN_GAP:    cfg_min_gap    = data;
            REG_MAX_GAP:    cfg_max_gap    = data;
            REG_MIN_STREAK: cfg_min_streak = data[3:0];
            REG_MAX_RISE:   cfg_max_rise   = data[6:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (accel_beats.size() != 0 || i_in_valid || predicted_reports.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_all(int thr, int min_gap, int max_gap, int streak, int rise);
        write_reg(REG_THRESHOLD, thr[7:0]);
        write_reg(REG_MIN_GAP, min_gap[7:0]);
        write_reg(REG_MAX_GAP, max_gap[7:0]);
        write_reg(REG_MIN_STREAK, streak[7:0]);
        write_reg(REG_MAX_RISE, rise[7:0]);
    endtask

    initial begin
        int kind;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                wait_idle();
                case (p)
                    1: write_all(0, 0, 0, 8'h01, 0);
                    2: write_all(255, 255, 255, 8'hff, 8'hff);
                    3: begin
                        // upper nibble must be dropped, leaving a minimum streak of zero
                        write_all(0, 0, 255, 8'hf0, 8'h7f);
                        for (int k = 1; k <= 3; k++)
                            write_reg(REG_MAX_RISE + CFG_IDX_W'(k), 8'($urandom));
                    end
                    4: write_all(THRESHOLD_RST, MIN_GAP_RST, MAX_GAP_RST, 10, 100);
                    default: write_all($urandom_range(160, 40), $urandom_range(12, 0),
                                       $urandom_range(45, 8), $urandom_range(255, 0),
                                       $urandom_range(127, 10));
                endcase
            end
            @(negedge i_clk);
            idle_odds  = (p == 2 || p == 5) ? 0 : $urandom_range(12, 3);
            quiet_tail = (p == PHASES - 1);
            phase_fill = 0;

            if (p == 0) begin
                add_beat(OP_SAMPLE, 0, 0, 0);
                add_beat(OP_SAMPLE, -32768, -32768, -32768);
                add_beat(OP_SAMPLE, 32767, 0, 0);
                add_beat(OP_SAMPLE, 0, -32768, 0);
                add_beat(OP_SAMPLE, 0, 0, 32767);
                add_beat(OP_SAMPLE, -1, -1, -1);
                add_beat(OP_SAMPLE, 32767, -32768, 32767);
                add_beat(OP_SAMPLE, 5000, -30000, 12000);
                add_beat(OP_SAMPLE, -30000, 5000, 12000);
                add_beat(OP_SAMPLE, 12000, 5000, -30000);
                add_beat(OP_SAMPLE, 256, 255, -256);
                add_beat(OP_CLEAR, -1, -1, -1);
                add_beat(OP_SAMPLE, -24576, 0, 0);
                // settle the history, then a taken candidate and a too-soon one
                repeat (10) add_level(100);
            end
            if (p == 3) add_steady(300);

            while (phase_fill < PHASE_BEATS) begin
                kind = $urandom_range(19, 0);
                if (kind < 14) add_walk($urandom_range(6, 1));
                else if (kind < 17) add_noise($urandom_range(8, 1));
                else if (kind < 19) add_steady($urandom_range(30, 5));
                else add_beat(OP_CLEAR, $urandom, $urandom, $urandom);
            end
            // long receiver stall while the queue is full, so the input backs up
            if (p == 3) hold_request = 1'b1;
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/pedo_pkg.sv
rtl/core/pedo_mag.sv
rtl/core/pedo_rise_cell.sv
rtl/core/pedometer_step_detector_unit.sv
bench/testbench.sv
